/* rtl/core/dwc_pkg.sv */
// Shared types and constants for the depthwise 11x11 int8 convolution.
// Used by dwc_front, dwc_back and the top level; depends on nothing.
`default_nettype none
package dwc_pkg;
   localparam int KERNEL_SIZE     = 11;
   localparam int TAPS            = KERNEL_SIZE * KERNEL_SIZE;
   localparam int LINES           = KERNEL_SIZE - 1;
   localparam int MAX_WIDTH_DEF   = 256;
   localparam int MAX_HEIGHT_DEF  = 256;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_BIAS_VALUE   = 3'd2;
   localparam logic [2:0] REG_SCALE_FACTOR = 3'd3;
   localparam logic [2:0] REG_RELU_FLOOR   = 3'd4;

   localparam logic [8:0]  IMAGE_WIDTH_RST  = 9'd256;
   localparam logic [8:0]  IMAGE_HEIGHT_RST = 9'd256;
   localparam logic [31:0] SCALE_RST        = 32'h0100_0000;
   localparam logic [7:0]  RELU_RST         = 8'h80;

   typedef enum logic [1:0] {
      KIND_TAP,
      KIND_PIXEL,
      KIND_DROP
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [6:0]  tap;
      logic [7:0]  data;
   } item_type;
endpackage
`default_nettype wire

/* rtl/core/dwc_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none
module dwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/core/dwc_front.sv */
// Front end: accepts request beats, classifies them and queues them.
// Depends on dwc_pkg.
`default_nettype none
module dwc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_action,
   input  wire logic [6:0]        req_tap_index,
   input  wire logic [7:0]        req_data_value,
   output logic                   item_valid,
   input  wire logic              item_ready,
   output dwc_pkg::item_type      item
);
   dwc_pkg::item_type slot_ff [dwc_pkg::QUEUE_DEPTH];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   dwc_pkg::item_type entry_in;
   logic              push;
   logic              pop;

   always_comb begin
      entry_in.tap  = req_tap_index;
      entry_in.data = req_data_value;
      if (req_action) begin
         entry_in.kind = dwc_pkg::KIND_PIXEL;
      end else if (32'(req_tap_index) < dwc_pkg::TAPS) begin
         entry_in.kind = dwc_pkg::KIND_TAP;
      end else begin
         entry_in.kind = dwc_pkg::KIND_DROP;
      end
   end

   assign req_ready  = (count_ff != 2'(dwc_pkg::QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_valid && item_ready;
   assign item       = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end
endmodule
`default_nettype wire

/* rtl/core/dwc_back.sv */
// Back end: line stores, 11x11 window, serial MAC, requantization and
// result register. Depends on dwc_pkg and dwc_ram.
`default_nettype none
module dwc_back #(
   parameter int MAX_WIDTH  = dwc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = dwc_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   output logic                   item_ready,
   input  wire dwc_pkg::item_type item,
   input  wire logic [8:0]        image_width,
   input  wire logic [8:0]        image_height,
   input  wire logic [31:0]       bias_value,
   input  wire logic [31:0]       scale_factor,
   input  wire logic [7:0]        relu_floor,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_out_value,
   output logic [7:0]             rsp_out_row,
   output logic [7:0]             rsp_out_col,
   output logic                   rsp_out_last
);
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int LAW  = $clog2(dwc_pkg::LINES * MAX_WIDTH);
   localparam int TAW  = $clog2(dwc_pkg::TAPS);
   localparam int KW   = $clog2(dwc_pkg::LINES + 2);
   localparam int MW   = $clog2(dwc_pkg::TAPS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_LINE, S_SHIFT, S_MAC, S_MUL, S_RND, S_OUT
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] col_cnt_ff;
   logic [RW-1:0] row_cnt_ff;
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic          last_ff;
   logic          emit_ff;
   logic [7:0]    pix_ff;
   logic [KW-1:0] k_ff;
   logic [MW-1:0] m_ff;
   logic [7:0]    vert_ff [dwc_pkg::LINES];
   logic [7:0]    win_ff  [dwc_pkg::TAPS];
   logic [31:0]   acc_ff;
   logic          neg_ff;
   logic [63:0]   prod_ff;
   logic [7:0]    val_ff;

   logic [WW-1:0] w_use;
   logic [HW-1:0] h_use;
   logic [CW-1:0] col_use;
   logic [RW-1:0] row_use;
   logic          col_end;
   logic          row_end;
   logic          pop;
   logic          tw_en;
   logic [7:0]    tap_q;
   logic [LAW-1:0] lr_addr;
   logic          lw_en;
   logic [LAW-1:0] lw_addr;
   logic [7:0]    lw_data;
   logic [7:0]    lr_q;
   logic [31:0]   lw_row;
   logic signed [15:0] mac_prod;
   logic [31:0]   mag;
   logic [64:0]   rsum;
   logic [40:0]   rnd;
   logic signed [7:0] sat;

   always_comb begin
      if (32'(image_width) < dwc_pkg::KERNEL_SIZE) begin
         w_use = WW'(dwc_pkg::KERNEL_SIZE);
      end else if (32'(image_width) > MAX_WIDTH) begin
         w_use = WW'(MAX_WIDTH);
      end else begin
         w_use = WW'(image_width);
      end
      if (32'(image_height) < dwc_pkg::KERNEL_SIZE) begin
         h_use = HW'(dwc_pkg::KERNEL_SIZE);
      end else if (32'(image_height) > MAX_HEIGHT) begin
         h_use = HW'(MAX_HEIGHT);
      end else begin
         h_use = HW'(image_height);
      end
      col_use = (WW'(col_cnt_ff) >= w_use) ? '0 : col_cnt_ff;
      row_use = (HW'(row_cnt_ff) >= h_use) ? '0 : row_cnt_ff;
      col_end = (WW'(col_use) + WW'(1) == w_use);
      row_end = (HW'(row_use) + HW'(1) == h_use);
   end

   assign item_ready = (state_ff == S_IDLE);
   assign pop        = item_valid && item_ready;
   assign tw_en      = pop && (item.kind == dwc_pkg::KIND_TAP);

   dwc_ram #(.WIDTH(8), .DEPTH(dwc_pkg::TAPS)) u_tap_ram (
      .clock   (clock),
      .wr_en   (tw_en),
      .wr_addr (item.tap),
      .wr_data (item.data),
      .rd_addr (TAW'(m_ff)),
      .rd_data (tap_q)
   );

   always_comb begin
      lr_addr = LAW'(32'(k_ff) * MAX_WIDTH + 32'(col_ff));
      lw_row  = (32'(k_ff) == dwc_pkg::LINES + 1) ? 32'(dwc_pkg::LINES - 1)
                                                  : 32'(k_ff) - 32'd2;
      lw_addr = LAW'(lw_row * MAX_WIDTH + 32'(col_ff));
      lw_data = (32'(k_ff) == dwc_pkg::LINES + 1) ? pix_ff : lr_q;
      lw_en   = (state_ff == S_LINE) && (32'(k_ff) >= 2);
   end

   dwc_ram #(.WIDTH(8), .DEPTH(dwc_pkg::LINES * MAX_WIDTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (lw_en),
      .wr_addr (lw_addr),
      .wr_data (lw_data),
      .rd_addr (lr_addr),
      .rd_data (lr_q)
   );

   always_comb begin
      mac_prod = $signed(tap_q) * $signed(win_ff[0]);
      mag      = acc_ff[31] ? (~acc_ff + 32'd1) : acc_ff;
      rsum     = {1'b0, prod_ff} + 65'h80_0000;
      rnd      = rsum[64:24];
      if (neg_ff) begin
         sat = (rnd > 41'd128) ? -8'sd128 : $signed(~rnd[7:0] + 8'd1);
      end else begin
         sat = (rnd > 41'd127) ? 8'sd127 : $signed(rnd[7:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         rsp_valid  <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready && state_ff != S_OUT) rsp_valid <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (pop && item.kind == dwc_pkg::KIND_PIXEL) begin
                  col_ff  <= col_use;
                  row_ff  <= row_use;
                  last_ff <= col_end && row_end;
                  emit_ff <= (32'(col_use) >= dwc_pkg::LINES)
                          && (32'(row_use) >= dwc_pkg::LINES);
                  pix_ff  <= item.data;
                  k_ff    <= '0;
                  if (col_end) begin
                     col_cnt_ff <= '0;
                     row_cnt_ff <= row_end ? '0 : row_use + RW'(1);
                  end else begin
                     col_cnt_ff <= col_use + CW'(1);
                     row_cnt_ff <= row_use;
                  end
                  state_ff <= S_LINE;
               end
            end
            S_LINE: begin
               if (32'(k_ff) >= 1 && 32'(k_ff) <= dwc_pkg::LINES) begin
                  for (int i = 0; i < dwc_pkg::LINES - 1; i++) begin
                     vert_ff[i] <= vert_ff[i+1];
                  end
                  vert_ff[dwc_pkg::LINES-1] <= lr_q;
               end
               if (32'(k_ff) == dwc_pkg::LINES + 1) begin
                  state_ff <= S_SHIFT;
               end
               k_ff <= k_ff + KW'(1);
            end
            S_SHIFT: begin
               for (int r = 0; r < dwc_pkg::KERNEL_SIZE; r++) begin
                  for (int c = 0; c < dwc_pkg::KERNEL_SIZE - 1; c++) begin
                     win_ff[r*dwc_pkg::KERNEL_SIZE+c] <= win_ff[r*dwc_pkg::KERNEL_SIZE+c+1];
                  end
               end
               for (int r = 0; r < dwc_pkg::LINES; r++) begin
                  win_ff[r*dwc_pkg::KERNEL_SIZE+dwc_pkg::KERNEL_SIZE-1] <= vert_ff[r];
               end
               win_ff[dwc_pkg::TAPS-1] <= pix_ff;
               acc_ff   <= bias_value;
               m_ff     <= '0;
               state_ff <= emit_ff ? S_MAC : S_IDLE;
            end
            S_MAC: begin
               if (m_ff != '0) begin
                  acc_ff <= acc_ff + {{16{mac_prod[15]}}, mac_prod};
                  for (int i = 0; i < dwc_pkg::TAPS - 1; i++) begin
                     win_ff[i] <= win_ff[i+1];
                  end
                  win_ff[dwc_pkg::TAPS-1] <= win_ff[0];
               end
               if (32'(m_ff) == dwc_pkg::TAPS) begin
                  state_ff <= S_MUL;
               end
               m_ff <= m_ff + MW'(1);
            end
            S_MUL: begin
               neg_ff   <= acc_ff[31];
               prod_ff  <= 64'(mag) * 64'(scale_factor);
               state_ff <= S_RND;
            end
            S_RND: begin
               val_ff   <= (sat < $signed(relu_floor)) ? relu_floor : sat;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid || rsp_ready) begin
                  rsp_valid     <= 1'b1;
                  rsp_out_value <= val_ff;
                  rsp_out_row   <= 8'(32'(row_ff) - 32'(dwc_pkg::LINES));
                  rsp_out_col   <= 8'(32'(col_ff) - 32'(dwc_pkg::LINES));
                  rsp_out_last  <= last_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* rtl/core/depthwise_conv11x11_int8_requant.sv */
// Top level of the depthwise 11x11 int8 convolution with requantization.
// Depends on dwc_pkg, dwc_front and dwc_back.
//
// Request channel (req_): one beat is a weight tap load (action 0) or one
// padded input pixel in raster order (action 1). Result channel (rsp_):
// one beat per pixel that completes an 11x11 window, with its output row,
// column and a last flag on the final pixel of the frame.
// Configuration: APB-style csr_ port, registers at byte address 4*i; the user
// writes them only while the block is idle; the block does not enforce it.
// A two-entry queue sits between the request port and the datapath.
// A tap load is written straight into the tap store. A pixel's datapath time
// is bounded by the line store port moving one stored row per cycle; a pixel
// that gives a result is further bounded by the single shared multiplier
// stepping through the 121 taps, plus the scale multiply, rounding and the
// result register.
// Reset clears the counts, the queue and the result valid flag and loads
// the register defaults; taps and line stores are undefined until written.
// A stalled receiver holds the result register; the queue keeps taking
// requests until it is full.
`default_nettype none
module depthwise_conv11x11_int8_requant #(
   parameter int MAX_WIDTH  = dwc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = dwc_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_action,
   input  wire logic [6:0]  req_tap_index,
   input  wire logic [7:0]  req_data_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_value,
   output logic [7:0]       rsp_out_row,
   output logic [7:0]       rsp_out_col,
   output logic             rsp_out_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [8:0]        image_width_ff;
   logic [8:0]        image_height_ff;
   logic [31:0]       bias_value_ff;
   logic [31:0]       scale_factor_ff;
   logic [7:0]        relu_floor_ff;
   logic              csr_wr;
   logic [2:0]        csr_idx;
   logic              item_valid;
   logic              item_ready;
   dwc_pkg::item_type item;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= dwc_pkg::IMAGE_WIDTH_RST;
         image_height_ff <= dwc_pkg::IMAGE_HEIGHT_RST;
         bias_value_ff   <= '0;
         scale_factor_ff <= dwc_pkg::SCALE_RST;
         relu_floor_ff   <= dwc_pkg::RELU_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            dwc_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= csr_pwdata[8:0];
            dwc_pkg::REG_IMAGE_HEIGHT: image_height_ff <= csr_pwdata[8:0];
            dwc_pkg::REG_BIAS_VALUE:   bias_value_ff   <= csr_pwdata;
            dwc_pkg::REG_SCALE_FACTOR: scale_factor_ff <= csr_pwdata;
            dwc_pkg::REG_RELU_FLOOR:   relu_floor_ff   <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         dwc_pkg::REG_IMAGE_WIDTH:  csr_prdata = 32'(image_width_ff);
         dwc_pkg::REG_IMAGE_HEIGHT: csr_prdata = 32'(image_height_ff);
         dwc_pkg::REG_BIAS_VALUE:   csr_prdata = bias_value_ff;
         dwc_pkg::REG_SCALE_FACTOR: csr_prdata = scale_factor_ff;
         dwc_pkg::REG_RELU_FLOOR:   csr_prdata = 32'(relu_floor_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   dwc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_tap_index  (req_tap_index),
      .req_data_value (req_data_value),
      .item_valid     (item_valid),
      .item_ready     (item_ready),
      .item           (item)
   );

   dwc_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item_ready    (item_ready),
      .item          (item),
      .image_width   (image_width_ff),
      .image_height  (image_height_ff),
      .bias_value    (bias_value_ff),
      .scale_factor  (scale_factor_ff),
      .relu_floor    (relu_floor_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_value (rsp_out_value),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_last  (rsp_out_last)
   );
endmodule
`default_nettype wire

/* rtl/core/dwc_checker.sv */
// Port-level checks for the depthwise convolution top level, and the bind
// that attaches them. Depends on depthwise_conv11x11_int8_requant.
`default_nettype none
module dwc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_value,
   input wire logic [7:0] rsp_out_row,
   input wire logic [7:0] rsp_out_col,
   input wire logic       rsp_out_last
);
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_value)
         && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_out_last))
      else $error("stalled result changed");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_row <= 8'd245 && rsp_out_col <= 8'd245)
      else $error("result position out of range");
endmodule

bind depthwise_conv11x11_int8_requant dwc_checker u_dwc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_value (rsp_out_value),
   .rsp_out_row   (rsp_out_row),
   .rsp_out_col   (rsp_out_col),
   .rsp_out_last  (rsp_out_last)
);
`default_nettype wire
